[rtl/bfbr_pkg.sv]
// Shared types, constants and codes for the best-fit buffer reuse planner.
package bfbr_pkg;

    localparam int MAX_BUFFERS = 64;
    localparam int SIZE_BITS   = 32;
    localparam int TOTAL_BITS  = 48;
    localparam int IDX_BITS    = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_BUFFERS + 1);

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [TOTAL_BITS-1:0] total_t;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_COMMIT
    } state_t;

    // Search record that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic  valid;
        cmd_t  cmd;
        size_t need;
        idx_t  rel_idx;
        logic  fit_found;
        idx_t  fit_idx;
        size_t fit_cap;
        logic  big_found;
        idx_t  big_idx;
        size_t big_cap;
        size_t rel_cap;
    } sweep_t;

    // Broadcast write that claims one slot at the end of an allocate.
    typedef struct packed {
        logic  en;
        idx_t  idx;
        size_t cap;
    } wr_t;

endpackage

[rtl/bfbr_cell.sv]
// One buffer slot: capacity and busy mark, plus one stage of the search record.
module bfbr_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  bfbr_pkg::idx_t     cell_index,
    input  bfbr_pkg::cnt_t     open_count,
    input  bfbr_pkg::wr_t      wr,
    input  bfbr_pkg::sweep_t   sweep_in,
    output bfbr_pkg::sweep_t   sweep_out
);

    bfbr_pkg::size_t  cap_reg;
    logic             busy_reg;
    logic             busy_next;
    logic             valid_reg;
    bfbr_pkg::sweep_t pay_reg;
    bfbr_pkg::sweep_t pay_next;

    logic is_open;
    logic is_free;
    logic take_fit;
    logic take_big;
    logic rel_hit;
    logic wr_hit;

    always_comb
    begin
        is_open  = bfbr_pkg::cnt_t'(cell_index) < open_count;
        is_free  = sweep_in.valid && (sweep_in.cmd == bfbr_pkg::CMD_ALLOC)
                   && is_open && !busy_reg;
        take_fit = is_free && (cap_reg >= sweep_in.need)
                   && (!sweep_in.fit_found || (cap_reg < sweep_in.fit_cap));
        take_big = is_free && (!sweep_in.big_found || (cap_reg > sweep_in.big_cap));
        rel_hit  = sweep_in.valid && (sweep_in.cmd == bfbr_pkg::CMD_RELEASE)
                   && is_open && (sweep_in.rel_idx == cell_index);
        wr_hit   = wr.en && (wr.idx == cell_index);

        pay_next = sweep_in;
        if (take_fit)
        begin
            pay_next.fit_found = 1'b1;
            pay_next.fit_idx   = cell_index;
            pay_next.fit_cap   = cap_reg;
        end
        if (take_big)
        begin
            pay_next.big_found = 1'b1;
            pay_next.big_idx   = cell_index;
            pay_next.big_cap   = cap_reg;
        end
        if (rel_hit)
        begin
            pay_next.rel_cap = cap_reg;
        end

        busy_next = busy_reg;
        if (wr_hit)
        begin
            busy_next = 1'b1;
        end
        else if (rel_hit)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= sweep_in.valid;
        end
    end

    // Capacity is only read once the slot is open, so it needs no reset.
    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
        if (wr_hit)
        begin
            cap_reg <= wr.cap;
        end
    end

    always_comb
    begin
        sweep_out       = pay_reg;
        sweep_out.valid = valid_reg;
    end

endmodule

[rtl/bfbr_chain.sv]
// Row of buffer cells; the search record ripples from slot 0 to the last slot.
module bfbr_chain
(
    input  logic               clk,
    input  logic               rst_n,
    input  bfbr_pkg::cnt_t     open_count,
    input  bfbr_pkg::wr_t      wr,
    input  bfbr_pkg::sweep_t   head,
    output bfbr_pkg::sweep_t   tail
);

    bfbr_pkg::sweep_t link [bfbr_pkg::MAX_BUFFERS+1];

    assign link[0] = head;

    for (genvar i = 0; i < bfbr_pkg::MAX_BUFFERS; i++)
    begin : g_cell
        bfbr_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (bfbr_pkg::idx_t'(i)),
            .open_count (open_count),
            .wr         (wr),
            .sweep_in   (link[i]),
            .sweep_out  (link[i+1])
        );
    end

    assign tail = link[bfbr_pkg::MAX_BUFFERS];

endmodule

[rtl/best_fit_buffer_reuse_planner.sv]
// Top level of the best-fit buffer reuse planner: handshake, sequencing, totals.
//
// Usage:
//   Input transactions arrive on the s_* stream. s_tuser is the command
//   (0 allocate, 1 release); s_tdata carries the byte need and the release
//   index. Every command yields exactly one result transaction on m_*.
//   Each command launches a search record into a row of 64 slot cells; the
//   record moves one cell per clock, so every slot is visited in turn. Best
//   fit and largest free buffer are tracked in the same pass. After the last
//   cell the top level commits: it claims, grows or opens a slot and updates
//   the saturating totals. Release clears the busy mark as the record passes.
//   On its way to result valid the command passes the launch register,
//   the register of every cell, the commit job register and the output
//   register. Only one command is in flight at a time.
//   The result sits in an output register; s_tready returns as soon as the
//   commit is done, so the next command walks the row while the previous
//   result waits. A commit waits while that register is still full.
//   Reset (rst_n low, asynchronous) empties the table: no slot open, all
//   buffers free, totals zero. Slot capacities are not cleared.
module best_fit_buffer_reuse_planner
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // bytes_needed[31:0], release_index[37:32], zero pad
    input  logic         s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata    // buffer_index[5:0], opened_new[6], grew_capacity[7],
                                    // capacity[39:8], buffer_count[46:40],
                                    // requested_total[94:47], arena_total[142:95],
                                    // status[144:143], zero pad
);

    bfbr_pkg::state_t state_reg, state_next;

    bfbr_pkg::cnt_t   count_reg,  count_next;
    bfbr_pkg::total_t needs_reg,  needs_next;
    bfbr_pkg::total_t arena_reg,  arena_next;

    logic             launch_valid_reg;
    bfbr_pkg::sweep_t launch_reg;
    bfbr_pkg::sweep_t head;
    bfbr_pkg::sweep_t tail;
    bfbr_pkg::sweep_t job_reg;
    bfbr_pkg::wr_t    wr;

    logic in_fire;
    logic commit_fire;

    // Result fields computed at commit.
    bfbr_pkg::idx_t    res_idx;
    logic              res_opened;
    logic              res_grew;
    bfbr_pkg::size_t   res_cap;
    bfbr_pkg::status_t res_status;
    bfbr_pkg::size_t   grow_delta;

    // Output register.
    logic              out_valid_reg;
    logic [5:0]        out_idx_reg;
    logic              out_opened_reg;
    logic              out_grew_reg;
    logic [31:0]       out_cap_reg;
    logic [6:0]        out_count_reg;
    logic [47:0]       out_req_reg;
    logic [47:0]       out_arena_reg;
    bfbr_pkg::status_t out_status_reg;

    function automatic bfbr_pkg::total_t sat_add(input bfbr_pkg::total_t a,
                                                 input bfbr_pkg::total_t b);
        logic [bfbr_pkg::TOTAL_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[bfbr_pkg::TOTAL_BITS] ? {bfbr_pkg::TOTAL_BITS{1'b1}}
                                         : sum[bfbr_pkg::TOTAL_BITS-1:0];
    endfunction

    // ---------------- cell row ----------------
    always_comb
    begin
        head       = launch_reg;
        head.valid = launch_valid_reg;
    end

    bfbr_chain u_chain
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .open_count (count_reg),
        .wr         (wr),
        .head       (head),
        .tail       (tail)
    );

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfbr_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bfbr_pkg::S_SWEEP;
                end
            end
            bfbr_pkg::S_SWEEP:
            begin
                if (tail.valid)
                begin
                    state_next = bfbr_pkg::S_COMMIT;
                end
            end
            bfbr_pkg::S_COMMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = bfbr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfbr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = (state_reg == bfbr_pkg::S_IDLE);
        in_fire     = s_tvalid && s_tready;
        commit_fire = (state_reg == bfbr_pkg::S_COMMIT) && (!out_valid_reg || m_tready);
    end

    // ---------------- commit decision ----------------
    always_comb
    begin
        res_idx    = '0;
        res_opened = 1'b0;
        res_grew   = 1'b0;
        res_cap    = '0;
        res_status = bfbr_pkg::ST_OK;
        count_next = count_reg;
        needs_next = needs_reg;
        arena_next = arena_reg;
        grow_delta = job_reg.need - job_reg.big_cap;
        wr.en      = 1'b0;
        wr.idx     = '0;
        wr.cap     = job_reg.need;

        if (job_reg.cmd == bfbr_pkg::CMD_RELEASE)
        begin
            res_idx = job_reg.rel_idx;
            if (bfbr_pkg::cnt_t'(job_reg.rel_idx) < count_reg)
            begin
                res_cap = job_reg.rel_cap;
            end
            else
            begin
                res_status = bfbr_pkg::ST_BAD_INDEX;
            end
        end
        else
        begin
            needs_next = sat_add(needs_reg, bfbr_pkg::total_t'(job_reg.need));
            priority if (job_reg.fit_found)
            begin
                res_idx = job_reg.fit_idx;
                res_cap = job_reg.fit_cap;
                wr.en   = 1'b1;
                wr.idx  = job_reg.fit_idx;
                wr.cap  = job_reg.fit_cap;
            end
            else if (job_reg.big_found)
            begin
                // No free buffer fits, so every free one is smaller than the need.
                res_idx    = job_reg.big_idx;
                res_cap    = job_reg.need;
                res_grew   = 1'b1;
                arena_next = sat_add(arena_reg, bfbr_pkg::total_t'(grow_delta));
                wr.en      = 1'b1;
                wr.idx     = job_reg.big_idx;
            end
            else if (count_reg != bfbr_pkg::cnt_t'(bfbr_pkg::MAX_BUFFERS))
            begin
                res_idx    = bfbr_pkg::idx_t'(count_reg);
                res_cap    = job_reg.need;
                res_opened = 1'b1;
                count_next = count_reg + bfbr_pkg::cnt_t'(1);
                arena_next = sat_add(arena_reg, bfbr_pkg::total_t'(job_reg.need));
                wr.en      = 1'b1;
                wr.idx     = bfbr_pkg::idx_t'(count_reg);
            end
            else
            begin
                res_status = bfbr_pkg::ST_FULL;
            end
        end

        wr.en = wr.en && commit_fire;
        if (!commit_fire)
        begin
            count_next = count_reg;
            needs_next = needs_reg;
            arena_next = arena_reg;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bfbr_pkg::S_IDLE;
            count_reg        <= '0;
            needs_reg        <= '0;
            arena_reg        <= '0;
            launch_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            needs_reg        <= needs_next;
            arena_reg        <= arena_next;
            launch_valid_reg <= in_fire;
            if (commit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            launch_reg.valid     <= 1'b1;
            launch_reg.cmd       <= bfbr_pkg::cmd_t'(s_tuser);
            launch_reg.need      <= bfbr_pkg::size_t'(s_tdata[31:0]);
            launch_reg.rel_idx   <= bfbr_pkg::idx_t'(s_tdata[37:32]);
            launch_reg.fit_found <= 1'b0;
            launch_reg.fit_idx   <= '0;
            launch_reg.fit_cap   <= '0;
            launch_reg.big_found <= 1'b0;
            launch_reg.big_idx   <= '0;
            launch_reg.big_cap   <= '0;
            launch_reg.rel_cap   <= '0;
        end
        if ((state_reg == bfbr_pkg::S_SWEEP) && tail.valid)
        begin
            job_reg <= tail;
        end
        if (commit_fire)
        begin
            out_idx_reg    <= 6'(res_idx);
            out_opened_reg <= res_opened;
            out_grew_reg   <= res_grew;
            out_cap_reg    <= 32'(res_cap);
            out_count_reg  <= 7'(count_next);
            out_req_reg    <= 48'(needs_next);
            out_arena_reg  <= 48'(arena_next);
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_status_reg, out_arena_reg, out_req_reg, out_count_reg,
                       out_cap_reg, out_grew_reg, out_opened_reg, out_idx_reg};

endmodule

[tb/best_fit_buffer_reuse_planner_test.sv]
// Self-checking testbench for the best-fit buffer reuse planner, scripted and random commands.
module best_fit_buffer_reuse_planner_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Result transaction, laid out so that it maps straight onto m_tdata[144:0]
    // (first member is the most significant).
    typedef struct packed {
        bfbr_pkg::status_t status;
        bfbr_pkg::total_t  arena;
        bfbr_pkg::total_t  req;
        bfbr_pkg::cnt_t    count;
        bfbr_pkg::size_t   cap;
        logic              grew;
        logic              opened;
        bfbr_pkg::idx_t    buf_idx;
    } result_t;

    // One scripted command; want is used only when typed is set.
    typedef struct packed {
        bfbr_pkg::cmd_t    cmd;
        bfbr_pkg::size_t   need;
        bfbr_pkg::idx_t    idx;
        logic              typed;
        result_t           want;
    } row_t;

    localparam int SCRIPT_LEN   = 23;
    localparam int RANDOM_ITEMS = 500;
    localparam int STALL_AT     = 150;   // result count at which the sink holds off
    localparam int STALL_CYCLES = 500;   // long enough to back the block up
    localparam int IDLE_LIMIT   = 4000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 80;    // a bit more than one row walk

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;

    // Shadow of the buffer table, updated as each command is accepted.
    bfbr_pkg::size_t   cap_tbl  [bfbr_pkg::MAX_BUFFERS];
    logic              busy_tbl [bfbr_pkg::MAX_BUFFERS];
    int                open_cnt;
    bfbr_pkg::total_t  req_sum;
    bfbr_pkg::total_t  arena_sum;

    result_t planned_results[$];
    row_t    script [SCRIPT_LEN];
    int      sent;
    int      received;
    int      failures;

    always #1 clk = ~clk;

    best_fit_buffer_reuse_planner DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic bfbr_pkg::total_t sat_add(bfbr_pkg::total_t a, bfbr_pkg::total_t b);
        logic [bfbr_pkg::TOTAL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[bfbr_pkg::TOTAL_BITS] ? '1 : s[bfbr_pkg::TOTAL_BITS-1:0];
    endfunction

    // Applies one command to the shadow table and returns the result it
    // should produce.
    function automatic result_t plan_command(bfbr_pkg::cmd_t cmd, bfbr_pkg::size_t need,
                                             bfbr_pkg::idx_t rel);
        result_t r;
        int      pick;
        logic    hit;
        r    = '0;
        pick = 0;
        hit  = 1'b0;
        if (cmd == bfbr_pkg::CMD_RELEASE)
        begin
            r.buf_idx = rel;
            if (int'(rel) >= open_cnt)
                r.status = bfbr_pkg::ST_BAD_INDEX;
            else
            begin
                busy_tbl[rel] = 1'b0;   // freeing a free buffer is harmless
                r.cap         = cap_tbl[rel];
                r.status      = bfbr_pkg::ST_OK;
            end
        end
        else
        begin
            // The need counts toward the request total even when the table is full.
            req_sum = sat_add(req_sum, bfbr_pkg::total_t'(need));
            // Best fit: smallest free buffer that holds the need, lowest index on ties.
            for (int b = 0; b < open_cnt; b++)
            begin
                if (!busy_tbl[b] && cap_tbl[b] >= need
                    && (!hit || cap_tbl[b] < cap_tbl[pick]))
                begin
                    pick = b;
                    hit  = 1'b1;
                end
            end
            if (hit)
            begin
                busy_tbl[pick] = 1'b1;
                r.buf_idx      = bfbr_pkg::idx_t'(pick);
                r.cap          = cap_tbl[pick];
            end
            else
            begin
                // Nothing fits: stretch the largest free buffer, lowest index on ties.
                for (int b = 0; b < open_cnt; b++)
                begin
                    if (!busy_tbl[b] && (!hit || cap_tbl[b] > cap_tbl[pick]))
                    begin
                        pick = b;
                        hit  = 1'b1;
                    end
                end
                if (hit)
                begin
                    arena_sum      = sat_add(arena_sum,
                                             bfbr_pkg::total_t'(need - cap_tbl[pick]));
                    cap_tbl[pick]  = need;
                    busy_tbl[pick] = 1'b1;
                    r.buf_idx      = bfbr_pkg::idx_t'(pick);
                    r.grew         = 1'b1;
                    r.cap          = need;
                end
                else if (open_cnt >= bfbr_pkg::MAX_BUFFERS)
                    r.status = bfbr_pkg::ST_FULL;
                else
                begin
                    pick           = open_cnt;
                    open_cnt++;
                    cap_tbl[pick]  = need;
                    busy_tbl[pick] = 1'b1;
                    arena_sum      = sat_add(arena_sum, bfbr_pkg::total_t'(need));
                    r.buf_idx      = bfbr_pkg::idx_t'(pick);
                    r.opened       = 1'b1;
                    r.cap          = need;
                end
            end
        end
        r.count = bfbr_pkg::cnt_t'(open_cnt);
        r.req   = req_sum;
        r.arena = arena_sum;
        return r;
    endfunction

    // Handshake gaps: every hundred transactions start with a burst of
    // back-to-back traffic, otherwise a randomly drawn pause.
    function automatic int pause_len(int n);
        return (n % 100 < 15) ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Needs cluster on a few small values so that equal capacities and exact
    // fits show up often; the extremes and full-width values are mixed in.
    function automatic bfbr_pkg::size_t draw_need();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4,
            5, 6:    return bfbr_pkg::size_t'($urandom_range(0, 16) * 16);
            7, 8:    return bfbr_pkg::size_t'($urandom_range(0, 4095));
            default: return bfbr_pkg::size_t'($urandom);
        endcase
    endfunction

    // Offers one command on the slave side and records its result once the
    // transaction is taken.
    task automatic offer(input bfbr_pkg::cmd_t cmd, input bfbr_pkg::size_t need,
                         input bfbr_pkg::idx_t idx, input logic typed,
                         input result_t want);
        int      gap;
        result_t r;
        gap = pause_len(sent);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, idx, need};
        do @(posedge clk); while (!s_tready);
        r = plan_command(cmd, need, idx);
        planned_results.push_back(typed ? want : r);
        sent++;
    endtask

    // Stimulus: reset, scripted corner cases, then random traffic.
    initial
    begin
        bfbr_pkg::cmd_t  cmd;
        bfbr_pkg::size_t need;
        bfbr_pkg::idx_t  idx;
        int              alloc_pct;

        for (int b = 0; b < bfbr_pkg::MAX_BUFFERS; b++)
        begin
            cap_tbl[b]  = '0;
            busy_tbl[b] = 1'b0;
        end
        open_cnt  = 0;
        req_sum   = '0;
        arena_sum = '0;
        sent      = 0;
        received  = 0;
        failures  = 0;

        // Slot notes track the table: (index:capacity, B busy / F free).
        script = '{
            // releases into an empty table are bad indexes
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd0, 1'b1,
              '{status: bfbr_pkg::ST_BAD_INDEX, default: '0}},
            '{bfbr_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 6'd63, 1'b1,
              '{buf_idx: 6'd63, status: bfbr_pkg::ST_BAD_INDEX, default: '0}},
            // zero need opens a zero-sized slot; full-width need opens slot 1
            '{bfbr_pkg::CMD_ALLOC, 32'h0, 6'd63, 1'b1,
              '{opened: 1'b1, count: 7'd1, status: bfbr_pkg::ST_OK, default: '0}},
            '{bfbr_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 6'd0, 1'b1,
              '{buf_idx: 6'd1, opened: 1'b1, cap: 32'hFFFF_FFFF, count: 7'd2,
                req: 48'hFFFF_FFFF, arena: 48'hFFFF_FFFF, status: bfbr_pkg::ST_OK,
                default: '0}},
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd1, 1'b0, '0},
            '{bfbr_pkg::CMD_ALLOC, 32'd100, 6'd0, 1'b0, '0},         // reuse 1 as is
            '{bfbr_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 6'd0, 1'b0, '0},
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd1, 1'b0, '0},         // 0:0 F, 1:max F
            '{bfbr_pkg::CMD_ALLOC, 32'd50, 6'd0, 1'b0, '0},          // fits 1 only
            '{bfbr_pkg::CMD_ALLOC, 32'd60, 6'd0, 1'b0, '0},          // grows 0 to 60
            '{bfbr_pkg::CMD_ALLOC, 32'd10, 6'd0, 1'b0, '0},          // opens 2
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd2, 1'b0, '0},
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd2, 1'b0, '0},         // already free
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd3, 1'b0, '0},         // not open yet
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd0, 1'b0, '0},         // 0:60 F, 2:10 F
            '{bfbr_pkg::CMD_ALLOC, 32'd60, 6'd0, 1'b0, '0},          // exact fit on 0
            '{bfbr_pkg::CMD_ALLOC, 32'd60, 6'd0, 1'b0, '0},          // grows 2 to 60
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd0, 1'b0, '0},
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd2, 1'b0, '0},         // 0:60 F, 2:60 F
            '{bfbr_pkg::CMD_ALLOC, 32'd20, 6'd0, 1'b0, '0},          // best-fit tie -> 0
            '{bfbr_pkg::CMD_RELEASE, 32'h0, 6'd0, 1'b0, '0},
            '{bfbr_pkg::CMD_ALLOC, 32'd100, 6'd0, 1'b0, '0},         // largest tie -> 0
            '{bfbr_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 6'd0, 1'b0, '0}    // grows 2 to max
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < SCRIPT_LEN; n++)
            offer(script[n].cmd, script[n].need, script[n].idx, script[n].typed,
                  script[n].want);

        // Random traffic in three phases: allocate-heavy to fill the table and
        // hit the full case, release-heavy to churn reuse and growth, then mixed.
        // The field a command ignores still carries random bits.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            alloc_pct = (n < 150) ? 85 : (n < 350) ? 45 : 70;
            cmd  = ($urandom_range(0, 99) < alloc_pct) ? bfbr_pkg::CMD_ALLOC
                                                       : bfbr_pkg::CMD_RELEASE;
            need = draw_need();
            idx  = bfbr_pkg::idx_t'($urandom_range(0, 63));
            // mostly open slots, now and then any index
            if (cmd == bfbr_pkg::CMD_RELEASE && open_cnt != 0 && $urandom_range(0, 7) != 0)
                idx = bfbr_pkg::idx_t'($urandom_range(0, open_cnt - 1));
            offer(cmd, need, idx, 1'b0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (planned_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: random ready gaps, one long hold-off, field-by-field check.
    initial
    begin
        int      gap;
        result_t got;
        result_t want;

        @(posedge rst_n);
        forever
        begin
            gap = (received == STALL_AT) ? STALL_CYCLES : pause_len(received);
            @(negedge clk);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = result_t'(m_tdata[144:0]);
            if (planned_results.size() == 0)
            begin
                $error("result transaction with none outstanding: %h", m_tdata);
                failures++;
            end
            else
            begin
                want = planned_results.pop_front();
                if (got.buf_idx !== want.buf_idx)
                begin
                    $error("buffer_index: expected %0d actual %0d", want.buf_idx, got.buf_idx);
                    failures++;
                end
                if (got.opened !== want.opened)
                begin
                    $error("opened_new: expected %0d actual %0d", want.opened, got.opened);
                    failures++;
                end
                if (got.grew !== want.grew)
                begin
                    $error("grew_capacity: expected %0d actual %0d", want.grew, got.grew);
                    failures++;
                end
                if (got.cap !== want.cap)
                begin
                    $error("capacity: expected %0h actual %0h", want.cap, got.cap);
                    failures++;
                end
                if (got.count !== want.count)
                begin
                    $error("buffer_count: expected %0d actual %0d", want.count, got.count);
                    failures++;
                end
                if (got.req !== want.req)
                begin
                    $error("requested_total: expected %0h actual %0h", want.req, got.req);
                    failures++;
                end
                if (got.arena !== want.arena)
                begin
                    $error("arena_total: expected %0h actual %0h", want.arena, got.arena);
                    failures++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, got.status);
                    failures++;
                end
            end
            received++;
        end
    end

    // Watchdog: any transaction on either side restarts the count.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $error("no transaction for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
